### rtl/pida_pkg.sv
package pida_pkg;

  // Default sizes of the store
  localparam int DEPTH_DEF      = 32;
  localparam int WORD_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [1:0] OP_REMOVE = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Cell modes
  localparam logic [1:0] CM_HOLD = 2'd0;
  localparam logic [1:0] CM_INS  = 2'd1;
  localparam logic [1:0] CM_REM  = 2'd2;
  localparam logic [1:0] CM_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  position;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_data;
    logic [31:0] data;
    logic [4:0]  entry_index;
    logic [5:0]  fill;
    logic        last;
  } out_item_t;

  // Broadcast control to every cell of the row
  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] idx;
  } cell_ctrl_t;

endpackage

### rtl/positional_insert_delete_array.sv
// Insert, remove, unused opcode and dump of an empty store: one result, shown
// the cycle after the item is accepted; such items may be taken every cycle.
// Non-empty dump: one result per stored entry on consecutive cycles, the first
// coming from the dump state through the output register; busy is high while
// the row rotates, and no new item is accepted then. The receiver cannot stall.
// Synchronous active-low reset empties the store; entries are not cleared.
module positional_insert_delete_array #(
  parameter int DEPTH      = pida_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = pida_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pida_pkg::in_item_t  in_item,
  output logic                out_valid,
  output pida_pkg::out_item_t out_item
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int CellW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                state_r, state_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic [5:0]          dump_idx_r, dump_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  pida_pkg::out_item_t out_r, out_nxt;

  pida_pkg::cell_ctrl_t ctrl;
  logic [CellW-1:0]     word;
  logic [CellW-1:0]     cell_q [DEPTH];
  logic                 accept;
  logic [7:0]           pos_w, cnt_w;

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CellW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    pida_cell #(
      .CELL_W   (CellW),
      .CELL_IDX (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .word  (word),
      .left  (left_w),
      .right (right_w),
      .q     (cell_q[i])
    );
  end

  assign busy   = (state_r == S_DUMP);
  assign accept = start && !busy;
  assign pos_w  = 8'(in_item.position);
  assign cnt_w  = 8'(count_r);

  // Decode the item, drive the row and build the next result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dump_idx_nxt  = dump_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.fill  = 6'(count_r);
    out_nxt.last  = 1'b1;
    ctrl.mode     = pida_pkg::CM_HOLD;
    ctrl.idx      = 6'(in_item.position - 6'd1);
    word          = in_item.value[CellW-1:0];

    if (state_r == S_DUMP) begin
      // Emit the front entry and rotate the stored entries forward
      out_valid_nxt        = 1'b1;
      out_nxt.status       = pida_pkg::ST_OK;
      out_nxt.has_data     = 1'b1;
      out_nxt.data[CellW-1:0] = cell_q[0];
      out_nxt.entry_index  = 5'(dump_idx_r);
      out_nxt.last         = ((8'(dump_idx_r) + 8'd1) == cnt_w);
      ctrl.mode            = pida_pkg::CM_ROT;
      ctrl.idx             = 6'(cnt_w - 8'd1);
      word                 = cell_q[0];
      dump_idx_nxt         = dump_idx_r + 6'd1;
      if (out_nxt.last) state_nxt = S_IDLE;
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      case (in_item.operation)
        pida_pkg::OP_INSERT: begin
          if (cnt_w >= 8'(DEPTH)) begin
            out_nxt.status = pida_pkg::ST_FULL;
          end else if (pos_w < 8'd1 || pos_w > cnt_w + 8'd1) begin
            out_nxt.status = pida_pkg::ST_RANGE;
          end else begin
            ctrl.mode    = pida_pkg::CM_INS;
            count_nxt    = count_r + CntW'(1);
            out_nxt.fill = 6'(count_nxt);
          end
        end
        pida_pkg::OP_REMOVE: begin
          if (cnt_w == 8'd0) begin
            out_nxt.status = pida_pkg::ST_EMPTY;
          end else if (pos_w < 8'd1 || pos_w > cnt_w) begin
            out_nxt.status = pida_pkg::ST_RANGE;
          end else begin
            ctrl.mode    = pida_pkg::CM_REM;
            count_nxt    = count_r - CntW'(1);
            out_nxt.fill = 6'(count_nxt);
          end
        end
        pida_pkg::OP_DUMP: begin
          if (cnt_w == 8'd0) begin
            out_nxt.status = pida_pkg::ST_EMPTY;
          end else begin
            // Results come from the dump state that this item enters
            out_valid_nxt = 1'b0;
            state_nxt     = S_DUMP;
            dump_idx_nxt  = 6'd0;
          end
        end
        default: out_nxt.status = pida_pkg::ST_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### rtl/pida_cell.sv
module pida_cell #(
  parameter int CELL_W   = 32,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  pida_pkg::cell_ctrl_t ctrl,
  input  logic [CELL_W-1:0]    word,
  input  logic [CELL_W-1:0]    left,
  input  logic [CELL_W-1:0]    right,
  output logic [CELL_W-1:0]    q
);

  localparam logic [5:0] MyIdx = 6'(CELL_IDX);

  logic [CELL_W-1:0] q_r;
  logic [CELL_W-1:0] q_nxt;

  // Pick the next entry from a neighbor, the broadcast word, or hold
  always_comb begin
    q_nxt = q_r;
    case (ctrl.mode)
      pida_pkg::CM_INS: begin
        if (MyIdx > ctrl.idx) q_nxt = left;
        else if (MyIdx == ctrl.idx) q_nxt = word;
      end
      pida_pkg::CM_REM: begin
        if (MyIdx >= ctrl.idx) q_nxt = right;
      end
      pida_pkg::CM_ROT: begin
        if (MyIdx == ctrl.idx) q_nxt = word;
        else if (MyIdx < ctrl.idx) q_nxt = right;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

### rtl/pida_chk.sv
module pida_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pida_pkg::in_item_t  in_item,
  input logic                out_valid,
  input pida_pkg::out_item_t out_item
);

  // A result only follows an accepted item or an ongoing dump
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a pending item");

  // Insert, remove and unused opcode answer with one final result in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation != pida_pkg::OP_DUMP)
      |=> (out_valid && out_item.last))
    else $error("insert or remove did not give one final result");

  // Dumped data always carries an ok status
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.has_data) |-> (out_item.status == pida_pkg::ST_OK))
    else $error("data result with bad status");

  // Block stays busy while a dump has more results to give
  a_busy_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("not busy in the middle of a dump");

  // A dump result that is not final is followed by another data result
  a_dump_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.has_data && !out_item.last)
      |=> (out_valid && out_item.has_data))
    else $error("gap in dump results");

endmodule

bind positional_insert_delete_array pida_chk u_pida_chk (.*);

### dv/positional_insert_delete_array_tb.sv
`timescale 1ns / 1ps

module positional_insert_delete_array_tb;

  localparam int CLK_PERIOD = 20;
  localparam int RANDOM_ITEMS = 310;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 2000;

  // Opcode with no defined operation
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    BURST_GROW,
    BURST_SHRINK,
    BURST_MIXED
  } burst_kind_t;

  // Shadow of the ordered store; predicts every result an item causes
  class row_scoreboard_t;
    logic [31:0] row[$];
    pida_pkg::out_item_t due_results[$];
    int errors = 0;
    int items_seen = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int peak_fill = 0;

    function int pending();
      return due_results.size();
    endfunction

    // Apply one accepted item to the shadow and queue its results
    function void take_item(pida_pkg::in_item_t it);
      pida_pkg::out_item_t r;
      int n;
      r = '0;
      r.last = 1'b1;
      n = row.size();
      items_seen++;
      case (it.operation)
        pida_pkg::OP_INSERT: begin
          if (n >= pida_pkg::DEPTH_DEF) begin
            r.status = pida_pkg::ST_FULL;
            full_rejects++;
          end else if (it.position < 1 || it.position > n + 1) begin
            r.status = pida_pkg::ST_RANGE;
          end else begin
            row.insert(int'(it.position) - 1, it.value);
            r.status = pida_pkg::ST_OK;
          end
        end
        pida_pkg::OP_REMOVE: begin
          if (n == 0) begin
            r.status = pida_pkg::ST_EMPTY;
          end else if (it.position < 1 || it.position > n) begin
            r.status = pida_pkg::ST_RANGE;
          end else begin
            row.delete(int'(it.position) - 1);
            r.status = pida_pkg::ST_OK;
          end
        end
        pida_pkg::OP_DUMP: begin
          if (n == 0) begin
            r.status = pida_pkg::ST_EMPTY;
          end else begin
            // One result per stored entry, last one flagged
            for (int i = 0; i < n; i++) begin
              r.status = pida_pkg::ST_OK;
              r.has_data = 1'b1;
              r.data = row[i];
              r.entry_index = i[4:0];
              r.fill = n[5:0];
              r.last = (i == n - 1);
              due_results.push_back(r);
            end
            return;
          end
        end
        default: r.status = pida_pkg::ST_RANGE;
      endcase
      r.fill = 6'(row.size());
      if (row.size() > peak_fill) peak_fill = row.size();
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result against the oldest prediction
    function void check_result(pida_pkg::out_item_t got);
      pida_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("has_data", 32'(want.has_data), 32'(got.has_data));
      compare_field("data", want.data, got.data);
      compare_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
      compare_field("fill", 32'(want.fill), 32'(got.fill));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pida_pkg::in_item_t in_item = '0;
  logic out_valid;
  pida_pkg::out_item_t out_item;

  row_scoreboard_t sb;
  int cycle_count = 0;
  int gen_fill = 0;
  bit no_idle = 1'b0;
  int sent = 0;

  positional_insert_delete_array i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("positional_insert_delete_array test failed");
      $finish;
    end
  end

  // Check results first, then note the item taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) sb.check_result(out_item);
      if (start && !busy) sb.take_item(in_item);
    end
  end

  // Present one item after a random gap (none if no_idle) and hold it until accepted
  task automatic send_item(logic [1:0] op, logic [5:0] pos, logic [31:0] val);
    pida_pkg::in_item_t it;
    int gap;
    it.operation = op;
    it.position = pos;
    it.value = val;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    // Track the fill on the stimulus side to aim positions
    if (op == pida_pkg::OP_INSERT && gen_fill < pida_pkg::DEPTH_DEF && pos >= 1 &&
        pos <= gen_fill + 1)
      gen_fill++;
    else if (op == pida_pkg::OP_REMOVE && gen_fill > 0 && pos >= 1 && pos <= gen_fill)
      gen_fill--;
  endtask

  // Draw one item, mostly well-formed, weighted by the burst kind
  task automatic send_random(burst_kind_t kind);
    int r;
    int ins_cut;
    int rem_cut;
    logic [31:0] val;
    logic [5:0] ins_pos;
    logic [5:0] rem_pos;
    r = $urandom_range(0, 99);
    case (kind)
      BURST_GROW: begin
        ins_cut = 78;
        rem_cut = 86;
      end
      BURST_SHRINK: begin
        ins_cut = 12;
        rem_cut = 86;
      end
      default: begin
        ins_cut = 42;
        rem_cut = 84;
      end
    endcase
    case ($urandom_range(0, 9))
      0: val = '0;
      1: val = '1;
      default: val = $urandom();
    endcase
    ins_pos = 6'($urandom_range(1, gen_fill + 1));
    rem_pos = (gen_fill == 0) ? 6'd1 : 6'($urandom_range(1, gen_fill));
    if (r < ins_cut) send_item(pida_pkg::OP_INSERT, ins_pos, val);
    else if (r < rem_cut) send_item(pida_pkg::OP_REMOVE, rem_pos, val);
    else if (r < 92) send_item(pida_pkg::OP_DUMP, 6'($urandom_range(0, 63)), val);
    else if (r < 98)
      send_item($urandom_range(0, 1) ? pida_pkg::OP_INSERT : pida_pkg::OP_REMOVE,
                6'($urandom_range(0, 63)), val);
    else send_item(OP_UNUSED, 6'($urandom_range(0, 63)), val);
  endtask

  initial begin
    burst_kind_t kind;
    int burst_len;
    int drain;
    sb = new();

    // Hold reset, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, range edges, front, middle and end, odd opcode
    send_item(pida_pkg::OP_DUMP, 6'd0, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd1, 32'h0);
    send_item(pida_pkg::OP_INSERT, 6'd0, 32'h1234_5678);
    send_item(pida_pkg::OP_INSERT, 6'd2, 32'h1234_5678);
    send_item(pida_pkg::OP_INSERT, 6'd1, 32'hFFFF_FFFF);
    send_item(pida_pkg::OP_INSERT, 6'd2, 32'h0000_0000);
    send_item(pida_pkg::OP_INSERT, 6'd1, 32'hA5A5_A5A5);
    send_item(pida_pkg::OP_INSERT, 6'd2, 32'h5A5A_5A5A);
    send_item(pida_pkg::OP_INSERT, 6'd63, 32'hFFFF_FFFF);
    send_item(pida_pkg::OP_REMOVE, 6'd0, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd5, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd63, 32'hFFFF_FFFF);
    send_item(pida_pkg::OP_DUMP, 6'd63, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send_item(pida_pkg::OP_REMOVE, 6'd4, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd1, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd1, 32'h0);
    send_item(pida_pkg::OP_DUMP, 6'd0, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd1, 32'h0);
    send_item(pida_pkg::OP_DUMP, 6'd0, 32'h0);

    // Fill to the top and push past it
    no_idle = 1'b1;
    repeat (36)
      send_item(pida_pkg::OP_INSERT, 6'($urandom_range(1, gen_fill + 1)), $urandom());
    send_item(pida_pkg::OP_DUMP, 6'd0, 32'h0);
    send_item(pida_pkg::OP_REMOVE, 6'd32, 32'h0);
    send_item(pida_pkg::OP_INSERT, 6'd32, 32'hFFFF_FFFF);

    // Random bursts that swing the fill up and down
    while (sent < RANDOM_ITEMS + 20) begin
      kind = burst_kind_t'($urandom_range(0, 2));
      burst_len = $urandom_range(10, 50);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        if (sent < RANDOM_ITEMS + 20) send_random(kind);
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    drain = 0;
    while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived: expected %p, actual none", $time,
               sb.pending(), sb.due_results[0]);
      sb.errors++;
    end

    $display("ran %0d items through the store, checked %0d results", sb.items_seen,
             sb.results_checked);
    $display("store peaked at %0d entries, %0d inserts refused as full", sb.peak_fill,
             sb.full_rejects);
    if (sb.errors == 0) begin
      $display("positional_insert_delete_array test passed");
    end else begin
      $display("positional_insert_delete_array test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pida_pkg.sv
rtl/pida_cell.sv
rtl/positional_insert_delete_array.sv
rtl/pida_chk.sv
dv/positional_insert_delete_array_tb.sv
